// ----- src/hslc_pkg.sv -----
package hslc_pkg;

	// default number of fraction bits in the internal fixed-point format
	localparam int unsigned FRAC_BITS_DEF = 16;

	// input scale: 16 fraction bits, 1.0 is 2^16
	localparam int unsigned IN_FRAC = 16;
	localparam logic [16:0] IN_ONE = 17'h10000;

	// segment of the piecewise-linear hue ramp
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_HIGH,
		SEG_FALL,
		SEG_LOW
	} seg_t;

	// per-stage load enables shared by the channel lanes
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_en_t;

endpackage

// ----- src/hsl_to_rgb_converter.sv -----
// HSL to 8-bit RGB color converter.
// Input channel: hue (16-bit fraction of a turn), saturation and lightness
// (17 bits, 65536 is 1.0, larger values are clamped to 1.0), qualified by
// in_valid; a transfer happens on a clock edge with in_valid high and
// in_stall low.
// Output channel: red, green, blue qualified by out_valid; the receiver
// holds out_stall high to keep the result in place.
// Five register stages: conversion and hue offsets, q from the l*s product,
// p and slope, ramp product per channel, byte scaling. A result is offered
// on out_valid once it is held in the byte scaling stage.
// Throughput is one color per clock while out_stall is low; each stage holds at most one item and
// a stage loads whenever it is empty or the stage after it moves on.
// While out_stall is high the pipeline fills its bubbles, then in_stall
// rises; no item is lost or repeated.
// Reset (arst_n low) empties all stages; no other state is kept.
module hsl_to_rgb_converter #(
	parameter int unsigned FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] hue,
	input  logic [16:0] saturation,
	input  logic [16:0] lightness,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);
	import hslc_pkg::*;

	localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'((64'd1 << FRAC_BITS) / 3);

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                   rdy1, rdy2, rdy3, rdy4, rdy5;
	pipe_en_t               en;
	logic [16:0]            sat_c, lit_c;
	logic [FRAC_BITS+15:0]  hue_ext;
	logic [FRAC_BITS+16:0]  sat_ext, lit_ext;
	logic [FRAC_BITS-1:0]   h_fx;
	logic [FRAC_BITS-1:0]   tr_s1, tg_s1, tb_s1;
	logic [FRAC_BITS:0]     s_s1, l_s1;
	logic [2*FRAC_BITS+1:0] ls_prod;
	logic [FRAC_BITS:0]     ls;
	logic [FRAC_BITS+1:0]   q_sum;
	logic [FRAC_BITS:0]     q_s2, l_s2;
	logic [FRAC_BITS+1:0]   p_diff;
	logic [FRAC_BITS:0]     ql_diff;
	logic [FRAC_BITS:0]     p_s3, q_s3, d_s3;

	// stage handshake: a stage loads when empty or when its successor loads
	always_comb begin
		rdy5     = !v_s5 || !out_stall;
		rdy4     = !v_s4 || rdy5;
		rdy3     = !v_s3 || rdy4;
		rdy2     = !v_s2 || rdy3;
		rdy1     = !v_s1 || rdy2;
		in_stall = !rdy1;
		en.en_s2 = rdy2;
		en.en_s3 = rdy3;
		en.en_s4 = rdy4;
		en.en_s5 = rdy5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// clamp and convert inputs to the internal format
	always_comb begin
		sat_c   = saturation[16] ? IN_ONE : saturation;
		lit_c   = lightness[16] ? IN_ONE : lightness;
		hue_ext = {hue, {FRAC_BITS{1'b0}}};
		sat_ext = {sat_c, {FRAC_BITS{1'b0}}};
		lit_ext = {lit_c, {FRAC_BITS{1'b0}}};
		h_fx    = hue_ext[IN_FRAC +: FRAC_BITS];
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			tr_s1 <= h_fx + THIRD;
			tg_s1 <= h_fx;
			tb_s1 <= h_fx - THIRD;
			s_s1  <= sat_ext[IN_FRAC +: FRAC_BITS+1];
			l_s1  <= lit_ext[IN_FRAC +: FRAC_BITS+1];
		end
	end

	// q from lightness and saturation
	always_comb begin
		ls_prod = {{(FRAC_BITS+1){1'b0}}, l_s1} * {{(FRAC_BITS+1){1'b0}}, s_s1};
		ls      = ls_prod[FRAC_BITS +: FRAC_BITS+1];
		if (!l_s1[FRAC_BITS] && !l_s1[FRAC_BITS-1]) begin
			q_sum = {1'b0, l_s1} + {1'b0, ls};
		end else begin
			q_sum = {1'b0, l_s1} + {1'b0, s_s1} - {1'b0, ls};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			q_s2 <= q_sum[FRAC_BITS:0];
			l_s2 <= l_s1;
		end
	end

	// p = 2l - q, slope d = q - p = 2(q - l)
	always_comb begin
		p_diff  = {l_s2, 1'b0} - {1'b0, q_s2};
		ql_diff = q_s2 - l_s2;
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			p_s3 <= p_diff[FRAC_BITS:0];
			q_s3 <= q_s2;
			d_s3 <= {ql_diff[FRAC_BITS-1:0], 1'b0};
		end
	end

	// one lane per channel, hue offset by +1/3, 0, -1/3
	hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
		.clk     (clk),
		.en      (en),
		.t_s1    (tr_s1),
		.p_s3    (p_s3),
		.q_s3    (q_s3),
		.d_s3    (d_s3),
		.byte_s5 (red)
	);

	hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
		.clk     (clk),
		.en      (en),
		.t_s1    (tg_s1),
		.p_s3    (p_s3),
		.q_s3    (q_s3),
		.d_s3    (d_s3),
		.byte_s5 (green)
	);

	hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
		.clk     (clk),
		.en      (en),
		.t_s1    (tb_s1),
		.p_s3    (p_s3),
		.q_s3    (q_s3),
		.d_s3    (d_s3),
		.byte_s5 (blue)
	);

	assign out_valid = v_s5;

	// an empty first stage always takes a transfer
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with an empty first stage");

	// an input transfer lands in the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted item missing from first stage");

	// a full pipeline under output stall pushes back on the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_stall) |-> in_stall)
		else $error("full pipeline accepted an item under stall");

	// a blocked middle stage keeps its item and data
	a_mid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy3) |=> (v_s3 && $stable(q_s3) && $stable(p_s3)))
		else $error("blocked stage lost its contents");

endmodule

// ----- src/hslc_chan.sv -----
module hslc_chan #(
	parameter int unsigned FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  hslc_pkg::pipe_en_t   en,
	input  logic [FRAC_BITS-1:0] t_s1,
	input  logic [FRAC_BITS:0]   p_s3,
	input  logic [FRAC_BITS:0]   q_s3,
	input  logic [FRAC_BITS:0]   d_s3,
	output logic [7:0]           byte_s5
);
	import hslc_pkg::*;

	localparam int unsigned W6 = FRAC_BITS + 3;
	localparam logic [W6-1:0] ONE6 = W6'(1) << FRAC_BITS;
	localparam logic [W6-1:0] FOUR6 = W6'(4) << FRAC_BITS;
	localparam logic [FRAC_BITS+1:0] TWO3 = (FRAC_BITS+2)'(2) << FRAC_BITS;

	logic [W6-1:0]          six_t;
	logic [FRAC_BITS+1:0]   three_t;
	logic [W6-1:0]          fall_m;
	seg_t                   seg_d;
	logic [FRAC_BITS:0]     m_d;
	seg_t                   seg_s2, seg_s3;
	logic [FRAC_BITS:0]     m_s2, m_s3;
	logic [2*FRAC_BITS+1:0] prod;
	logic [FRAC_BITS:0]     slope;
	logic [FRAC_BITS:0]     v_d;
	logic [FRAC_BITS:0]     v_s4;
	logic [FRAC_BITS+8:0]   scaled;
	logic [8:0]             byte_w;

	// segment select and ramp multiplier operand
	always_comb begin
		six_t   = {1'b0, t_s1, 2'b00} + {2'b00, t_s1, 1'b0};
		three_t = {1'b0, t_s1, 1'b0} + {2'b00, t_s1};
		fall_m  = FOUR6 - six_t;
		seg_d   = SEG_LOW;
		m_d     = '0;
		if (six_t < ONE6) begin
			seg_d = SEG_RISE;
			m_d   = six_t[FRAC_BITS:0];
		end else if (!t_s1[FRAC_BITS-1]) begin
			seg_d = SEG_HIGH;
		end else if (three_t < TWO3) begin
			seg_d = SEG_FALL;
			m_d   = fall_m[FRAC_BITS:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			seg_s2 <= seg_d;
			m_s2   <= m_d;
		end
		if (en.en_s3) begin
			seg_s3 <= seg_s2;
			m_s3   <= m_s2;
		end
	end

	// ramp value from p, q and the slope product
	always_comb begin
		prod  = {{(FRAC_BITS+1){1'b0}}, d_s3} * {{(FRAC_BITS+1){1'b0}}, m_s3};
		slope = prod[FRAC_BITS +: FRAC_BITS+1];
		unique case (seg_s3)
			SEG_RISE: v_d = p_s3 + slope;
			SEG_HIGH: v_d = q_s3;
			SEG_FALL: v_d = p_s3 + slope;
			SEG_LOW:  v_d = p_s3;
			default:  v_d = p_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			v_s4 <= v_d;
		end
	end

	// scale to a byte: floor(v * 255), clamped
	always_comb begin
		scaled = {v_s4, 8'h00} - {8'h00, v_s4};
		byte_w = scaled[FRAC_BITS +: 9];
	end

	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			byte_s5 <= byte_w[8] ? 8'hFF : byte_w[7:0];
		end
	end

endmodule

// ----- sim/hsl_to_rgb_converter_tb.sv -----
`timescale 1ns / 1ps

module hsl_to_rgb_converter_tb;

	import hslc_pkg::*;

	localparam int unsigned FRAC = FRAC_BITS_DEF;
	localparam logic [63:0] ONE = 64'd1 << FRAC;
	localparam logic [63:0] MASK = ONE - 64'd1;

	typedef struct {
		logic [15:0] h;
		logic [16:0] s;
		logic [16:0] l;
	} hsl_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] hue = '0;
	logic [16:0] saturation = '0;
	logic [16:0] lightness = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	hsl_t hsl_pending[$];
	rgb_t rgb_due[$];
	int unsigned mismatches = 0;
	int unsigned n_checked = 0;

	hsl_to_rgb_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hue(hue),
		.saturation(saturation),
		.lightness(lightness),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue)
	);

	// 16-fraction-bit input value to the internal format
	function automatic logic [63:0] to_frac(logic [63:0] v);
		if (FRAC >= IN_FRAC) begin
			return v << (FRAC - IN_FRAC);
		end
		return v >> (IN_FRAC - FRAC);
	endfunction

	// piecewise-linear hue ramp between lo and hi at position t
	function automatic logic [63:0] hue_ramp(logic [63:0] lo, logic [63:0] hi, logic [63:0] t);
		logic [63:0] span;
		span = hi - lo;
		if (64'd6 * t < ONE) begin
			return lo + ((span * (64'd6 * t)) >> FRAC);
		end
		if (64'd2 * t < ONE) begin
			return hi;
		end
		if (64'd3 * t < 64'd2 * ONE) begin
			return lo + ((span * (64'd4 * ONE - 64'd6 * t)) >> FRAC);
		end
		return lo;
	endfunction

	// channel value to an 8-bit level, floor(v*255)
	function automatic logic [7:0] to_level(logic [63:0] v);
		logic [63:0] b;
		b = (v * 64'd255) >> FRAC;
		return (b > 64'd255) ? 8'd255 : b[7:0];
	endfunction

	// expected color for one transfer
	function automatic rgb_t hsl_to_rgb(logic [15:0] h_in, logic [16:0] s_in, logic [16:0] l_in);
		logic [63:0] third, h, s, l, q, p, rv, gv, bv;
		rgb_t c;
		third = ONE / 64'd3;
		h = to_frac({48'd0, h_in}) & MASK;
		s = to_frac({47'd0, (s_in > IN_ONE) ? IN_ONE : s_in});
		l = to_frac({47'd0, (l_in > IN_ONE) ? IN_ONE : l_in});
		if (s == 64'd0) begin
			rv = l;
			gv = l;
			bv = l;
		end else begin
			if (64'd2 * l < ONE) begin
				q = (l * (ONE + s)) >> FRAC;
			end else begin
				q = l + s - ((l * s) >> FRAC);
			end
			p = 64'd2 * l - q;
			rv = hue_ramp(p, q, (h + third) & MASK);
			gv = hue_ramp(p, q, h);
			bv = hue_ramp(p, q, (h - third) & MASK);
		end
		c.r = to_level(rv);
		c.g = to_level(gv);
		c.b = to_level(bv);
		return c;
	endfunction

	task automatic queue_hsl(logic [15:0] h, logic [16:0] s, logic [16:0] l);
		hsl_t c;
		c.h = h;
		c.s = s;
		c.l = l;
		hsl_pending.push_back(c);
	endtask

	task automatic check_level(string chan, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, chan, want, got);
			mismatches++;
		end
	endtask

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// input driver: bursts of transfers with random gaps
	always @(posedge clk or negedge arst_n) begin : drive_in
		hsl_t nxt;
		int unsigned burst_left;
		int unsigned gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else if (!in_valid || !in_stall) begin
			// record the transfer that just completed
			if (in_valid) begin
				rgb_due.push_back(hsl_to_rgb(hue, saturation, lightness));
			end
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (hsl_pending.size() != 0) begin
				nxt = hsl_pending.pop_front();
				hue <= nxt.h;
				saturation <= nxt.s;
				lightness <= nxt.l;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall: modes of no stall, random stall and heavy stall
	always @(posedge clk or negedge arst_n) begin : drive_stall
		int unsigned mode;
		int unsigned mode_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			mode = 0;
			mode_left = 0;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 80);
			end else begin
				mode_left--;
			end
			case (mode)
				0: begin
					out_stall <= 1'b0;
				end
				1: begin
					out_stall <= ($urandom_range(0, 1) == 0);
				end
				default: begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	// monitor: compare each result transfer with the oldest expected color
	always @(posedge clk) begin : watch_out
		rgb_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rgb_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0d %0d %0d",
					$time, red, green, blue);
				mismatches++;
			end else begin
				want = rgb_due.pop_front();
				check_level("red", want.r, red);
				check_level("green", want.g, green);
				check_level("blue", want.b, blue);
				n_checked++;
			end
		end
	end

	// stimulus and end of run
	initial begin : stim
		logic [15:0] h;
		logic [16:0] s;
		logic [16:0] l;
		int unsigned n_total;

		// primary hues and ramp segment edges, mostly at full saturation, half lightness
		queue_hsl(16'd0, 17'd65536, 17'd32768);
		queue_hsl(16'd21845, 17'd65536, 17'd32768);
		queue_hsl(16'd43691, 17'd65536, 17'd32768);
		queue_hsl(16'd65535, 17'd65536, 17'd32768);
		queue_hsl(16'd10922, 17'd65536, 17'd32768);
		queue_hsl(16'd10923, 17'd65536, 17'd32768);
		queue_hsl(16'd32767, 17'd65536, 17'd32768);
		queue_hsl(16'd32768, 17'd65536, 17'd32768);
		queue_hsl(16'd43690, 17'd65536, 17'd32768);
		queue_hsl(16'd54613, 17'd65536, 17'd32768);
		queue_hsl(16'd54614, 17'd65536, 17'd32768);
		queue_hsl(16'd21846, 17'd40000, 17'd20000);
		// gray, with and without clamped lightness
		queue_hsl(16'd12345, 17'd0, 17'd40000);
		queue_hsl(16'd12345, 17'd0, 17'd131071);
		queue_hsl(16'd12345, 17'd1, 17'd0);
		// black and white
		queue_hsl(16'd0, 17'd65536, 17'd0);
		queue_hsl(16'd0, 17'd65536, 17'd65536);
		// saturation and lightness above 1.0
		queue_hsl(16'd5000, 17'd131071, 17'd32768);
		queue_hsl(16'd40000, 17'd65537, 17'd131071);
		// either side of half lightness
		queue_hsl(16'd30000, 17'd65535, 17'd32767);
		queue_hsl(16'd30000, 17'd65535, 17'd32768);
		queue_hsl(16'd50000, 17'd32768, 17'd65535);
		queue_hsl(16'd1, 17'd1, 17'd1);

		// random colors, mostly in range, some clamped or gray
		for (int i = 0; i < 400; i++) begin
			h = 16'($urandom);
			case ($urandom_range(0, 19))
				0: s = '0;
				1, 2: s = 17'($urandom);
				3: s = 17'd65536;
				default: s = 17'($urandom_range(0, 65536));
			endcase
			case ($urandom_range(0, 19))
				0: l = 17'($urandom_range(32760, 32776));
				1, 2: l = 17'($urandom);
				3: l = ($urandom_range(0, 1) == 0) ? 17'd0 : 17'd65536;
				default: l = 17'($urandom_range(0, 65536));
			endcase
			queue_hsl(h, s, l);
		end
		n_total = hsl_pending.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every queued item has come back as a result, then idle a while
		while (n_checked < n_total) @(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && rgb_due.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// timeout
	initial begin
		#200000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
src/hslc_pkg.sv
src/hslc_chan.sv
src/hsl_to_rgb_converter.sv
sim/hsl_to_rgb_converter_tb.sv
